[hdl/mip_pkg.sv]
package mip_pkg;

  localparam int DATA_W        = 32;
  localparam int SIZE_W        = 4;
  localparam int PIV_W         = 16;
  localparam int MAX_ORDER_DEF = 8;
  localparam int SIZE_RST      = 8;
  localparam int MINP_RST      = 1;
  // dividend magnitude: up to 2^47 for x * 2^16, 2^32 for the reciprocal
  localparam int DIV_W         = 48;
  localparam int DCNT_W        = $clog2(DIV_W);

  // configuration register indexes
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_MINP = 1'b1;

  function automatic logic [DATA_W-1:0] sat48(input logic [47:0] v);
    logic [DATA_W-1:0] r;
    if (!v[47] && (|v[46:31])) begin
      r = 32'h7fff_ffff;
    end else if (v[47] && !(&v[46:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] neg_sat32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    if (x == 32'h8000_0000) begin
      r = 32'h7fff_ffff;
    end else begin
      r = ~x + 32'd1;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

[hdl/mip_div.sv]
module mip_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mip_pkg::DIV_W-1:0]    num_mag,
  input  logic                         num_neg,
  input  logic [mip_pkg::DATA_W-1:0]   den,
  output logic                         done,
  output logic [mip_pkg::DATA_W-1:0]   quo
);
  import mip_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DATA_W-1:0]   dmag_r;
  logic                neg_r;
  logic [DATA_W-1:0]   q_r;

  logic [DATA_W:0]     trial;
  logic                qbit;
  logic [DATA_W-1:0]   rem_nxt;
  logic [DIV_W-1:0]    quo_nxt;
  logic [DATA_W-1:0]   q_nxt;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, dmag_r});
    rem_nxt = qbit ? DATA_W'(trial - {1'b0, dmag_r}) : trial[DATA_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], qbit};
    if (neg_r) begin
      q_nxt = (quo_nxt > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                    : (~quo_nxt[31:0] + 32'd1);
    end else begin
      q_nxt = (quo_nxt > DIV_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= num_mag;
      dmag_r <= mag32(den);
      neg_r  <= num_neg ^ den[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        q_r <= q_nxt;
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[hdl/mip_mac.sv]
module mip_mac (
  input  logic                        clk,
  input  logic [mip_pkg::DATA_W-1:0]  x,
  input  logic [mip_pkg::DATA_W-1:0]  y,
  input  logic [mip_pkg::DATA_W-1:0]  acc,
  output logic [mip_pkg::DATA_W-1:0]  sum
);
  import mip_pkg::*;

  logic signed [2*DATA_W-1:0] prod_r;
  logic [47:0]                scaled;
  logic [47:0]                total;

  always_ff @(posedge clk) begin
    prod_r <= $signed(x) * $signed(y);
  end

  // divide by 2^16 rounding toward zero, then saturating accumulate
  always_comb begin
    scaled = prod_r[63:16] + 48'(prod_r[63] && (|prod_r[15:0]));
    total  = {{16{acc[DATA_W-1]}}, acc} + scaled;
    sum    = sat48(total);
  end

endmodule

[hdl/matrix_inverse_full_pivot.sv]
// Q16.16 matrix inverter, Gauss-Jordan with full pivoting. The order n (1..MAX_ORDER, 0 reads
// as 1, larger values as MAX_ORDER) and the singular threshold are set on the cfg port while
// the block is idle; writing the order restarts loading. Elements are taken row-major, one
// transfer per cycle. After the n*n-th transfer the input stalls while one sequencer walks
// the matrix memory (one read port, one write port): pivot search, swaps, the rank-one
// update through one shared multiplier, and 2n-1 divides per elimination step on a shared
// radix-2 divider. Then n*n results follow, the last one with tlast. A pivot below
// min_pivot, or zero, ends the run with one transfer of value zero, tuser (singular) set
// and tlast set.
module matrix_inverse_full_pivot #(
  parameter int MAX_ORDER = mip_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mip_pkg::DATA_W-1:0]  in_tdata,   // [31:0] element
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mip_pkg::DATA_W-1:0]  out_tdata,  // [31:0] value
  output logic                        out_tuser,  // [0] singular
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mip_pkg::PIV_W-1:0]   cfg_wdata
);
  import mip_pkg::*;

  localparam int IW    = $clog2(MAX_ORDER);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_LOAD, S_SRCH_RD, S_SRCH_CMP, S_PIV_CHK,
    S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
    S_PIV_RD, S_PIV_LD, S_RS_RD, S_RS_GO,
    S_UP_RA, S_UP_RB, S_UP_RC, S_UP_MUL, S_UP_WR,
    S_CS_RD, S_CS_GO, S_RC_GO, S_DWAIT,
    S_US_C, S_US_R, S_US_NEXT,
    S_OUT_RD, S_OUT_LD, S_OUT_HOLD, S_SING
  } state_t;

  // swap kinds: forward swaps negate what lands at the far index, undo swaps the near one
  typedef enum logic [1:0] {SW_COLK, SW_ROWK, SW_UROW, SW_UCOL} swap_t;
  typedef enum logic [1:0] {DK_RS, DK_CS, DK_RC} dkind_t;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_ORDER) + AW'(c);
  endfunction

  // configuration
  logic [SIZE_W-1:0]  size_r;
  logic [PIV_W-1:0]   minp_r;
  logic [IW-1:0]      nm1;

  // sequencer state
  state_t             state_r;
  swap_t              mode_r;
  dkind_t             dkind_r;
  logic [IW-1:0]      row_r, col_r;
  logic [IW-1:0]      k_r, i_r, j_r, o_r;
  logic [IW-1:0]      br_r, bc_r;
  logic [DATA_W-1:0]  best_r;
  logic [DATA_W-1:0]  t_r, x_r, y_r, piv_r;
  logic [AW-1:0]      div_addr_r;
  logic [IW-1:0]      rowp_r [MAX_ORDER];
  logic [IW-1:0]      colp_r [MAX_ORDER];

  // output register
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  logic               out_sing_r;
  logic               out_last_r;

  // matrix memory, one port each way
  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rd_data_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [DATA_W-1:0]  mem_wd;

  // shared units
  logic               div_start, div_done, div_neg;
  logic [DIV_W-1:0]   div_num;
  logic [DATA_W-1:0]  div_q;
  logic [DATA_W-1:0]  mac_sum;

  logic               sw_col, sw_neg_a;
  logic [AW-1:0]      sw_a, sw_b;
  logic [DATA_W-1:0]  rd_mag;
  logic               up_skip, up_end;

  mip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_num),
    .num_neg (div_neg),
    .den     (piv_r),
    .done    (div_done),
    .quo     (div_q)
  );

  mip_mac u_mac (
    .clk (clk),
    .x   (x_r),
    .y   (y_r),
    .acc (rd_data_r),
    .sum (mac_sum)
  );

  // active order minus one, clamped
  always_comb begin
    if (size_r == '0) begin
      nm1 = '0;
    end else if ({1'b0, size_r} > (SIZE_W + 1)'(MAX_ORDER)) begin
      nm1 = IW'(MAX_ORDER - 1);
    end else begin
      nm1 = IW'(size_r - 1'b1);
    end
  end

  always_comb begin
    sw_col   = (mode_r == SW_COLK) || (mode_r == SW_UCOL);
    sw_neg_a = (mode_r == SW_UROW) || (mode_r == SW_UCOL);
    sw_a     = sw_col ? addr_of(i_r, k_r) : addr_of(k_r, i_r);
    sw_b     = sw_col ? addr_of(i_r, o_r) : addr_of(o_r, i_r);
    rd_mag   = mag32(rd_data_r);
    up_skip  = (i_r == k_r) || (j_r == k_r);
    up_end   = (i_r == nm1) && (j_r == nm1);
  end

  // memory and divider controls decoded from the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_neg   = 1'b0;
    case (state_r)
      S_LOAD: begin
        mem_we = in_tvalid;
        mem_wa = addr_of(row_r, col_r);
        mem_wd = in_tdata;
      end
      S_SRCH_RD: begin
        mem_re = 1'b1;
        mem_ra = addr_of(i_r, j_r);
      end
      S_SW_RDA: begin
        mem_re = 1'b1;
        mem_ra = sw_a;
      end
      S_SW_RDB: begin
        mem_re = 1'b1;
        mem_ra = sw_b;
      end
      S_SW_WRA: begin
        mem_we = 1'b1;
        mem_wa = sw_a;
        mem_wd = sw_neg_a ? neg_sat32(rd_data_r) : rd_data_r;
      end
      S_SW_WRB: begin
        mem_we = 1'b1;
        mem_wa = sw_b;
        mem_wd = sw_neg_a ? t_r : neg_sat32(t_r);
      end
      S_PIV_RD: begin
        mem_re = 1'b1;
        mem_ra = addr_of(k_r, k_r);
      end
      S_RS_RD: begin
        mem_re = (i_r != k_r);
        mem_ra = addr_of(k_r, i_r);
      end
      S_RS_GO: begin
        // quotient of the negated element
        div_start = 1'b1;
        div_num   = {rd_mag, 16'h0000};
        div_neg   = ~rd_data_r[DATA_W-1];
      end
      S_UP_RA: begin
        mem_re = !up_skip;
        mem_ra = addr_of(k_r, i_r);
      end
      S_UP_RB: begin
        mem_re = 1'b1;
        mem_ra = addr_of(j_r, k_r);
      end
      S_UP_RC: begin
        mem_re = 1'b1;
        mem_ra = addr_of(j_r, i_r);
      end
      S_UP_WR: begin
        mem_we = 1'b1;
        mem_wa = addr_of(j_r, i_r);
        mem_wd = mac_sum;
      end
      S_CS_RD: begin
        mem_re = (j_r != k_r);
        mem_ra = addr_of(j_r, k_r);
      end
      S_CS_GO: begin
        div_start = 1'b1;
        div_num   = {rd_mag, 16'h0000};
        div_neg   = rd_data_r[DATA_W-1];
      end
      S_RC_GO: begin
        // 2^32 / pivot
        div_start = 1'b1;
        div_num   = DIV_W'(33'h1_0000_0000);
        div_neg   = 1'b0;
      end
      S_DWAIT: begin
        mem_we = div_done;
        mem_wa = div_addr_r;
        mem_wd = div_q;
      end
      S_OUT_RD: begin
        mem_re = 1'b1;
        mem_ra = addr_of(i_r, j_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      size_r      <= SIZE_W'(SIZE_RST);
      minp_r      <= PIV_W'(MINP_RST);
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < MAX_ORDER; m++) begin
        rowp_r[m] <= '0;
        colp_r[m] <= '0;
      end
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_tvalid) begin
            if (col_r == nm1) begin
              col_r <= '0;
              if (row_r == nm1) begin
                row_r   <= '0;
                k_r     <= '0;
                i_r     <= '0;
                j_r     <= '0;
                br_r    <= '0;
                bc_r    <= '0;
                best_r  <= '0;
                state_r <= S_SRCH_RD;
              end else begin
                row_r <= row_r + 1'b1;
              end
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        S_SRCH_RD: state_r <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          // strict compare keeps the first maximum in scan order
          if (rd_mag > best_r) begin
            best_r <= rd_mag;
            br_r   <= i_r;
            bc_r   <= j_r;
          end
          if (j_r == nm1) begin
            j_r <= k_r;
            if (i_r == nm1) begin
              state_r <= S_PIV_CHK;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_SRCH_RD;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SRCH_RD;
          end
        end
        S_PIV_CHK: begin
          rowp_r[k_r] <= br_r;
          colp_r[k_r] <= bc_r;
          i_r         <= '0;
          if ((best_r == '0) || (best_r < {16'h0000, minp_r})) begin
            state_r <= S_SING;
          end else if (bc_r > k_r) begin
            mode_r  <= SW_COLK;
            o_r     <= bc_r;
            state_r <= S_SW_RDA;
          end else if (br_r > k_r) begin
            mode_r  <= SW_ROWK;
            o_r     <= br_r;
            state_r <= S_SW_RDA;
          end else begin
            state_r <= S_PIV_RD;
          end
        end
        S_SW_RDA: state_r <= S_SW_RDB;
        S_SW_RDB: begin
          t_r     <= rd_data_r;
          state_r <= S_SW_WRA;
        end
        S_SW_WRA: state_r <= S_SW_WRB;
        S_SW_WRB: begin
          if (i_r == nm1) begin
            i_r <= '0;
            case (mode_r)
              SW_COLK: begin
                if (br_r > k_r) begin
                  mode_r  <= SW_ROWK;
                  o_r     <= br_r;
                  state_r <= S_SW_RDA;
                end else begin
                  state_r <= S_PIV_RD;
                end
              end
              SW_ROWK: state_r <= S_PIV_RD;
              SW_UROW: state_r <= S_US_R;
              default: state_r <= S_US_NEXT;
            endcase
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SW_RDA;
          end
        end
        S_PIV_RD: state_r <= S_PIV_LD;
        S_PIV_LD: begin
          piv_r   <= rd_data_r;
          i_r     <= '0;
          state_r <= (rd_data_r == '0) ? S_SING : S_RS_RD;
        end
        S_RS_RD: begin
          if (i_r == k_r) begin
            if (i_r == nm1) begin
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_UP_RA;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            state_r <= S_RS_GO;
          end
        end
        S_RS_GO: begin
          div_addr_r <= addr_of(k_r, i_r);
          dkind_r    <= DK_RS;
          state_r    <= S_DWAIT;
        end
        S_UP_RA: begin
          if (up_skip) begin
            if (up_end) begin
              j_r     <= '0;
              state_r <= S_CS_RD;
            end else if (j_r == nm1) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            state_r <= S_UP_RB;
          end
        end
        S_UP_RB: begin
          x_r     <= rd_data_r;
          state_r <= S_UP_RC;
        end
        S_UP_RC: begin
          y_r     <= rd_data_r;
          state_r <= S_UP_MUL;
        end
        S_UP_MUL: state_r <= S_UP_WR;
        S_UP_WR: begin
          if (up_end) begin
            j_r     <= '0;
            state_r <= S_CS_RD;
          end else begin
            if (j_r == nm1) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            state_r <= S_UP_RA;
          end
        end
        S_CS_RD: begin
          if (j_r == k_r) begin
            if (j_r == nm1) begin
              state_r <= S_RC_GO;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            state_r <= S_CS_GO;
          end
        end
        S_CS_GO: begin
          div_addr_r <= addr_of(j_r, k_r);
          dkind_r    <= DK_CS;
          state_r    <= S_DWAIT;
        end
        S_RC_GO: begin
          div_addr_r <= addr_of(k_r, k_r);
          dkind_r    <= DK_RC;
          state_r    <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (dkind_r)
              DK_RS: begin
                if (i_r == nm1) begin
                  i_r     <= '0;
                  j_r     <= '0;
                  state_r <= S_UP_RA;
                end else begin
                  i_r     <= i_r + 1'b1;
                  state_r <= S_RS_RD;
                end
              end
              DK_CS: begin
                if (j_r == nm1) begin
                  state_r <= S_RC_GO;
                end else begin
                  j_r     <= j_r + 1'b1;
                  state_r <= S_CS_RD;
                end
              end
              default: begin
                // elimination step done
                if (k_r == nm1) begin
                  state_r <= S_US_C;
                end else begin
                  k_r     <= k_r + 1'b1;
                  i_r     <= k_r + 1'b1;
                  j_r     <= k_r + 1'b1;
                  br_r    <= k_r + 1'b1;
                  bc_r    <= k_r + 1'b1;
                  best_r  <= '0;
                  state_r <= S_SRCH_RD;
                end
              end
            endcase
          end
        end
        // undo the pivot swaps, last step first
        S_US_C: begin
          i_r <= '0;
          if (colp_r[k_r] > k_r) begin
            mode_r  <= SW_UROW;
            o_r     <= colp_r[k_r];
            state_r <= S_SW_RDA;
          end else begin
            state_r <= S_US_R;
          end
        end
        S_US_R: begin
          i_r <= '0;
          if (rowp_r[k_r] > k_r) begin
            mode_r  <= SW_UCOL;
            o_r     <= rowp_r[k_r];
            state_r <= S_SW_RDA;
          end else begin
            state_r <= S_US_NEXT;
          end
        end
        S_US_NEXT: begin
          if (k_r == '0) begin
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_OUT_RD;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= S_US_C;
          end
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          out_data_r  <= rd_data_r;
          out_sing_r  <= 1'b0;
          out_last_r  <= up_end;
          state_r     <= S_OUT_HOLD;
        end
        S_SING: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '0;
          out_sing_r  <= 1'b1;
          out_last_r  <= 1'b1;
          state_r     <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_LOAD;
            end else begin
              if (j_r == nm1) begin
                j_r <= '0;
                i_r <= i_r + 1'b1;
              end else begin
                j_r <= j_r + 1'b1;
              end
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase

      // register writes: the user must write them only while idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE: begin
            size_r <= cfg_wdata[SIZE_W-1:0];
            row_r  <= '0;
            col_r  <= '0;
          end
          REG_MINP: minp_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;
  assign out_tlast  = out_last_r;

endmodule

[tb/sv/matrix_inverse_full_pivot_tb.sv]
`timescale 1ns / 1ps

module matrix_inverse_full_pivot_tb;
  import mip_pkg::*;

  localparam int ORDER_MAX   = MAX_ORDER_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              singular;
    logic              last;
  } inverse_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;    // [31:0] element
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;        // [31:0] value
  logic                out_tuser;        // [0] singular
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_SIZE;
  logic [PIV_W-1:0]    cfg_wdata = '0;

  matrix_inverse_full_pivot uut (.*);

  always #10 clk = ~clk;

  // pending elements, expected inverse words, error tally
  logic [DATA_W-1:0] element_q[$];
  inverse_word_t     inverse_q[$];
  int                mismatches = 0;
  int                cycles = 0;
  bit                sender_hold = 1'b0;

  // shadow copy of the block state for prediction
  int                shadow_mat[ORDER_MAX][ORDER_MAX];
  int                row_swap[ORDER_MAX];
  int                col_swap[ORDER_MAX];
  int                loaded = 0;
  int                order_reg = SIZE_RST;
  int                pivot_floor = MINP_RST;

  function automatic int clip(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int negate(int v);
    return clip(-longint'(v));
  endfunction

  function automatic int qdiv(longint x, int p);
    return clip((x * 65536) / longint'(p));
  endfunction

  function automatic int qmac(int acc, int x, int y);
    return clip(longint'(acc) + (longint'(x) * longint'(y)) / 65536);
  endfunction

  function automatic longint magnitude(int v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic int active_order();
    if (order_reg < 1) return 1;
    if (order_reg > ORDER_MAX) return ORDER_MAX;
    return order_reg;
  endfunction

  // gauss-jordan exchange steps in place, 0 when a pivot is too small
  function automatic bit invert_shadow(int n);
    int     br, bc, piv, t, r, c;
    longint best;
    for (int k = 0; k < n; k++) begin
      br = k;
      bc = k;
      best = magnitude(shadow_mat[k][k]);
      for (int i = k; i < n; i++)
        for (int j = k; j < n; j++)
          if (magnitude(shadow_mat[i][j]) > best) begin
            best = magnitude(shadow_mat[i][j]);
            br = i;
            bc = j;
          end
      row_swap[k] = br;
      col_swap[k] = bc;
      if (best == 0 || best < longint'(pivot_floor)) return 1'b0;
      if (bc > k)
        for (int i = 0; i < n; i++) begin
          t = negate(shadow_mat[i][k]);
          shadow_mat[i][k] = shadow_mat[i][bc];
          shadow_mat[i][bc] = t;
        end
      if (br > k)
        for (int j = 0; j < n; j++) begin
          t = negate(shadow_mat[k][j]);
          shadow_mat[k][j] = shadow_mat[br][j];
          shadow_mat[br][j] = t;
        end
      piv = shadow_mat[k][k];
      if (piv == 0) return 1'b0;
      for (int i = 0; i < n; i++)
        if (i != k) shadow_mat[k][i] = qdiv(-longint'(shadow_mat[k][i]), piv);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (i != k && j != k)
            shadow_mat[j][i] = qmac(shadow_mat[j][i], shadow_mat[k][i], shadow_mat[j][k]);
      for (int j = 0; j < n; j++)
        if (j != k) shadow_mat[j][k] = qdiv(longint'(shadow_mat[j][k]), piv);
      shadow_mat[k][k] = clip((64'sd1 <<< 32) / longint'(piv));
    end
    // undo the swaps, last step first
    for (int k = n - 1; k >= 0; k--) begin
      c = col_swap[k];
      r = row_swap[k];
      if (c > k && c < n)
        for (int j = 0; j < n; j++) begin
          t = shadow_mat[k][j];
          shadow_mat[k][j] = negate(shadow_mat[c][j]);
          shadow_mat[c][j] = t;
        end
      if (r > k && r < n)
        for (int i = 0; i < n; i++) begin
          t = shadow_mat[i][k];
          shadow_mat[i][k] = negate(shadow_mat[i][r]);
          shadow_mat[i][r] = t;
        end
    end
    return 1'b1;
  endfunction

  // load one element; on the last one of a matrix queue the inverse
  function automatic void absorb_element(logic [DATA_W-1:0] e);
    int            n, total;
    inverse_word_t w;
    n = active_order();
    total = n * n;
    if (loaded >= total) loaded = 0;
    shadow_mat[loaded / n][loaded % n] = int'(e);
    loaded++;
    if (loaded < total) return;
    loaded = 0;
    if (!invert_shadow(n)) begin
      w.value = '0;
      w.singular = 1'b1;
      w.last = 1'b1;
      inverse_q.push_back(w);
    end else begin
      for (int idx = 0; idx < total; idx++) begin
        w.value = shadow_mat[idx / n][idx % n];
        w.singular = 1'b0;
        w.last = (idx + 1 == total);
        inverse_q.push_back(w);
      end
    end
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (element_q.size() > 0 && !sender_hold) begin
        in_tdata <= element_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 20);
          // about a third of bursts run straight into the next one
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random 16-bit stall pattern, redrawn each time it has run through, plus one long hold-off
  logic [15:0] ready_pattern = 16'hffff;
  int          window_pos = 0;
  int          hold_off = 0;
  bit          hold_done = 1'b0;
  int          results_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen == 3) begin
      // block fills up and must stall its input
      hold_done <= 1'b1;
      hold_off <= 3000;
      out_tready <= 1'b0;
    end else begin
      if (window_pos == 15) begin
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
        window_pos <= 0;
      end else begin
        window_pos <= window_pos + 1;
      end
      out_tready <= ready_pattern[window_pos];
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    inverse_word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) absorb_element(in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (inverse_q.size() == 0) begin
          $error("unexpected transfer: value %h singular %b last %b",
                 out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          w = inverse_q.pop_front();
          if (out_tdata !== w.value) begin
            $error("value: expected %h, actual %h", w.value, out_tdata);
            mismatches++;
          end
          if (out_tuser !== w.singular) begin
            $error("singular: expected %b, actual %b", w.singular, out_tuser);
            mismatches++;
          end
          if (out_tlast !== w.last) begin
            $error("last: expected %b, actual %b", w.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // register write, only while the block is idle
  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= PIV_W'(value);
    if (idx == REG_SIZE) begin
      order_reg = value & 'hf;
      loaded = 0;
    end else begin
      pivot_floor = value & 'hffff;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every element is taken and every result has arrived
  task automatic drain();
    while (element_q.size() > 0 || in_tvalid || inverse_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_order(int n);
    // upper data bits are ignored by the order register
    write_reg(REG_SIZE, n | ($urandom() & 'hfff0));
  endtask

  // one matrix of random content: well conditioned, raw noise or rank deficient
  task automatic queue_matrix(int n, int kind);
    int m[ORDER_MAX][ORDER_MAX];
    int dup;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (kind == 1) m[i][j] = $urandom();
        else if (i == j) m[i][j] = ($urandom_range(0, 1) ? 1 : -1)
                                   * (n * 131072 + $urandom_range(0, 262143));
        else m[i][j] = $urandom_range(0, 131071) - 65536;
      end
    if (kind == 2 && n > 1) begin
      dup = $urandom_range(1, n - 1);
      for (int j = 0; j < n; j++) m[dup][j] = m[0][j];
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) element_q.push_back(m[i][j]);
  endtask

  initial begin
    int pick, n, sent;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // order one: unit, extremes, the smallest negative value, zero pivot
    set_order(1);
    write_reg(REG_MINP, 1);
    element_q = '{32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0};
    drain();
    // zero pivot is singular even with no threshold
    write_reg(REG_MINP, 0);
    element_q.push_back(32'h0);
    drain();
    // threshold at its top: equal passes, one below fails
    write_reg(REG_MINP, 16'hffff);
    element_q = '{32'h0000_ffff, 32'h0000_fffe};
    drain();
    // order zero reads as one
    write_reg(REG_MINP, 1);
    set_order(0);
    element_q.push_back(32'h0002_0000);
    drain();
    // order two: identity, singular, pivot off the diagonal
    set_order(2);
    element_q = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
                  32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000,
                  32'h0000_1000, 32'h0003_0000, 32'hfffe_0000, 32'h0000_2000};
    drain();
    // writing the order in the middle of a load restarts it
    element_q = '{32'h1234_5678, 32'h8765_4321};
    drain();
    set_order(1);
    element_q.push_back(32'hfff0_0000);
    drain();

    // order above the maximum reads as the maximum: one full-size matrix
    set_order(15);
    queue_matrix(ORDER_MAX, 0);
    drain();

    // random phases, mostly small orders
    sent = 0;
    while (sent < 180) begin
      pick = $urandom_range(0, 9);
      n = (pick < 8) ? $urandom_range(1, 3) : 4;
      set_order(n);
      pick = $urandom_range(0, 9);
      write_reg(REG_MINP, (pick == 0) ? 0 : (pick == 1) ? 16'hffff : $urandom_range(1, 4096));
      for (int m = 0; m < 3; m++) begin
        pick = $urandom_range(0, 19);
        queue_matrix(n, (pick < 14) ? 0 : (pick < 17) ? 1 : 2);
        sent += n * n;
      end
      // now and then hold the sender until all results are back
      if ($urandom_range(0, 3) == 0) begin
        sender_hold = 1'b1;
        while (inverse_q.size() > 0 || in_tvalid) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
